### rtl/core/complex_arithmetic_unit_defines.svh
// Assertion macros for the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define CAU_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cau assertion failed");
// Next-cycle implication, disabled while reset is high.
`define CAU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cau assertion failed");
`else
`define CAU_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define CAU_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### rtl/core/cau_pkg.sv
// Package for the complex arithmetic unit: opcodes, stage types, saturation.
package cau_pkg;

   localparam int FRAC_BITS_DEFAULT = 8;

   localparam int DATA_W = 16;
   localparam int RES_W  = 17;
   localparam int PROD_W = 2 * DATA_W;
   localparam int WIDE_W = PROD_W + 1;
   localparam int ROOT_W = DATA_W;
   localparam int REM_W  = ROOT_W + 2;

   // Square root: four iterations in each of four stages
   localparam int SQRT_STEPS  = 4;
   localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

   localparam logic signed [RES_W-1:0]  RES_MAX  = 17'sd65535;
   localparam logic signed [RES_W-1:0]  RES_MIN  = -17'sd65536;
   localparam logic signed [WIDE_W-1:0] WIDE_MAX = 33'sd65535;
   localparam logic signed [WIDE_W-1:0] WIDE_MIN = -33'sd65536;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_SUB    = 3'd1,
      OP_MUL_RE = 3'd2,
      OP_MUL_IM = 3'd3,
      OP_CMUL   = 3'd4,
      OP_MAG    = 3'd5
   } op_type;

   // Product stage register
   typedef struct packed {
      logic                      valid;
      op_type                    op;
      logic signed [PROD_W-1:0]  p_rr;   // a_re * b_re
      logic signed [PROD_W-1:0]  p_ii;   // a_im * b_im
      logic signed [PROD_W-1:0]  p_ri;   // a_re * b_im
      logic signed [PROD_W-1:0]  p_ir;   // a_im * b_re
      logic signed [PROD_W-1:0]  p_aa;   // a_re * a_re
      logic signed [PROD_W-1:0]  p_bb;   // a_im * a_im
      logic signed [RES_W-1:0]   sum_re;
      logic signed [RES_W-1:0]   sum_im;
   } mul_type;

   // Root stage register; finished result parts ride along
   typedef struct packed {
      logic                     valid;
      logic                     is_mag;
      logic [PROD_W-1:0]        rad;
      logic [REM_W-1:0]         rem;
      logic [ROOT_W-1:0]        root;
      logic signed [RES_W-1:0]  re;
      logic signed [RES_W-1:0]  im;
      logic                     ovf;
   } sq_type;

   // Saturate to the result width; top bit is the overflow flag
   function automatic logic [RES_W:0] sat17(input logic signed [WIDE_W-1:0] v);
      logic [RES_W:0] r;
      if (v > WIDE_MAX) begin
         r = {1'b1, RES_MAX};
      end else if (v < WIDE_MIN) begin
         r = {1'b1, RES_MIN};
      end else begin
         r = {1'b0, v[RES_W-1:0]};
      end
      return r;
   endfunction

endpackage

### rtl/core/cau_mult_stage.sv
// First pipeline stage: operand products and add/subtract.
module cau_mult_stage (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  logic [2:0]                       in_op,
   input  logic signed [cau_pkg::DATA_W-1:0] in_a_re,
   input  logic signed [cau_pkg::DATA_W-1:0] in_a_im,
   input  logic signed [cau_pkg::DATA_W-1:0] in_b_re,
   input  logic signed [cau_pkg::DATA_W-1:0] in_b_im,
   output cau_pkg::mul_type                 out
);
   import cau_pkg::*;

   mul_type stage_in;
   mul_type stage_ff;
   logic signed [RES_W-1:0] a_re_x, a_im_x, b_re_x, b_im_x;

   // Sign-extended operands for the 17-bit add/subtract
   assign a_re_x = RES_W'(in_a_re);
   assign a_im_x = RES_W'(in_a_im);
   assign b_re_x = RES_W'(in_b_re);
   assign b_im_x = RES_W'(in_b_im);

   // Six 16x16 products, one add/subtract pair
   always_comb begin
      stage_in.valid = in_valid;
      stage_in.op    = op_type'(in_op);
      stage_in.p_rr  = PROD_W'(in_a_re) * PROD_W'(in_b_re);
      stage_in.p_ii  = PROD_W'(in_a_im) * PROD_W'(in_b_im);
      stage_in.p_ri  = PROD_W'(in_a_re) * PROD_W'(in_b_im);
      stage_in.p_ir  = PROD_W'(in_a_im) * PROD_W'(in_b_re);
      stage_in.p_aa  = PROD_W'(in_a_re) * PROD_W'(in_a_re);
      stage_in.p_bb  = PROD_W'(in_a_im) * PROD_W'(in_a_im);
      if (op_type'(in_op) == OP_SUB) begin
         stage_in.sum_re = a_re_x - b_re_x;
         stage_in.sum_im = a_im_x - b_im_x;
      end else begin
         stage_in.sum_re = a_re_x + b_re_x;
         stage_in.sum_im = a_im_x + b_im_x;
      end
   end

   // Valid is reset, payload is not
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign out = stage_ff;

endmodule

### rtl/core/cau_combine_stage.sv
// Second pipeline stage: product sums, floor shift, saturation, root radicand.
module cau_combine_stage #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  cau_pkg::mul_type in,
   output cau_pkg::sq_type  out
);
   import cau_pkg::*;

   sq_type stage_in;
   sq_type stage_ff;
   logic signed [WIDE_W-1:0] pre_re, pre_im;
   logic signed [WIDE_W-1:0] val_re, val_im;
   logic                     do_shift;
   logic [RES_W:0]           sat_re, sat_im;

   // Select the full-precision result parts per opcode
   always_comb begin
      pre_re   = '0;
      pre_im   = '0;
      do_shift = 1'b0;
      unique case (in.op)
         OP_ADD, OP_SUB: begin
            pre_re = WIDE_W'(in.sum_re);
            pre_im = WIDE_W'(in.sum_im);
         end
         OP_MUL_RE: begin
            pre_re   = WIDE_W'(in.p_rr);
            pre_im   = WIDE_W'(in.p_ir);
            do_shift = 1'b1;
         end
         OP_MUL_IM: begin
            pre_re   = -WIDE_W'(in.p_ir);
            pre_im   = WIDE_W'(in.p_rr);
            do_shift = 1'b1;
         end
         OP_CMUL: begin
            pre_re   = WIDE_W'(in.p_rr) - WIDE_W'(in.p_ii);
            pre_im   = WIDE_W'(in.p_ri) + WIDE_W'(in.p_ir);
            do_shift = 1'b1;
         end
         default: begin
            pre_re = '0;
            pre_im = '0;
         end
      endcase
   end

   // Arithmetic shift rounds toward minus infinity
   assign val_re = do_shift ? (pre_re >>> FRAC_BITS) : pre_re;
   assign val_im = do_shift ? (pre_im >>> FRAC_BITS) : pre_im;
   assign sat_re = sat17(val_re);
   assign sat_im = sat17(val_im);

   always_comb begin
      stage_in.valid  = in.valid;
      stage_in.is_mag = (in.op == OP_MAG);
      stage_in.rad    = {1'b0, in.p_aa[PROD_W-2:0]} + {1'b0, in.p_bb[PROD_W-2:0]};
      stage_in.rem    = '0;
      stage_in.root   = '0;
      stage_in.re     = sat_re[RES_W-1:0];
      stage_in.im     = sat_im[RES_W-1:0];
      stage_in.ovf    = sat_re[RES_W] | sat_im[RES_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign out = stage_ff;

endmodule

### rtl/core/cau_sqrt_stage.sv
// Square root stage: four digit-by-digit iterations, result parts pass through.
module cau_sqrt_stage (
   input  logic            clock,
   input  logic            reset,
   input  cau_pkg::sq_type in,
   output cau_pkg::sq_type out
);
   import cau_pkg::*;

   sq_type stage_in;
   sq_type stage_ff;
   logic [PROD_W-1:0] rad_v;
   logic [REM_W-1:0]  rem_v;
   logic [REM_W-1:0]  trial;
   logic [ROOT_W-1:0] root_v;

   // One root bit per iteration from the next two radicand bits
   always_comb begin
      rad_v  = in.rad;
      rem_v  = in.rem;
      root_v = in.root;
      trial  = '0;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         rem_v = {rem_v[REM_W-3:0], rad_v[PROD_W-1 -: 2]};
         rad_v = {rad_v[PROD_W-3:0], 2'b00};
         trial = {root_v, 2'b01};
         if (rem_v >= trial) begin
            rem_v  = rem_v - trial;
            root_v = {root_v[ROOT_W-2:0], 1'b1};
         end else begin
            root_v = {root_v[ROOT_W-2:0], 1'b0};
         end
      end
      stage_in      = in;
      stage_in.rad  = rad_v;
      stage_in.rem  = rem_v;
      stage_in.root = root_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign out = stage_ff;

endmodule

### rtl/core/complex_arithmetic_unit.sv
// Complex arithmetic unit top level: six-stage pipeline, one request per cycle.
// Throughput: one request per clock; busy stays low, the pipeline never stalls.
// Stages: products, sums and saturation, then four root stages of four bits each.
// Reset is synchronous and active high; it clears every stage's valid bit.
// The receiver cannot stall: rsp_valid marks each result for one cycle only.
`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit #(
   parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [2:0]                        req_op,
   input  logic signed [cau_pkg::DATA_W-1:0] req_a_re,
   input  logic signed [cau_pkg::DATA_W-1:0] req_a_im,
   input  logic signed [cau_pkg::DATA_W-1:0] req_b_re,
   input  logic signed [cau_pkg::DATA_W-1:0] req_b_im,
   output logic                              rsp_valid,
   output logic signed [cau_pkg::RES_W-1:0]  rsp_res_re,
   output logic signed [cau_pkg::RES_W-1:0]  rsp_res_im,
   output logic                              rsp_overflow
);
   import cau_pkg::*;

   mul_type mul_q;
   sq_type  sq_q [SQRT_STAGES+1];
   sq_type  last;
   logic    accept;

   // Every cycle can take a request
   assign busy   = 1'b0;
   assign accept = start & ~busy;

   cau_mult_stage u_mult (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_op    (req_op),
      .in_a_re  (req_a_re),
      .in_a_im  (req_a_im),
      .in_b_re  (req_b_re),
      .in_b_im  (req_b_im),
      .out      (mul_q)
   );

   cau_combine_stage #(
      .FRAC_BITS (FRAC_BITS)
   ) u_combine (
      .clock (clock),
      .reset (reset),
      .in    (mul_q),
      .out   (sq_q[0])
   );

   // Root stages in a chain
   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
      cau_sqrt_stage u_sqrt (
         .clock (clock),
         .reset (reset),
         .in    (sq_q[g]),
         .out   (sq_q[g+1])
      );
   end

   // Result select from the last stage register
   assign last         = sq_q[SQRT_STAGES];
   assign rsp_valid    = last.valid;
   assign rsp_res_re   = last.is_mag ? RES_W'({1'b0, last.root}) : last.re;
   assign rsp_res_im   = last.is_mag ? '0 : last.im;
   assign rsp_overflow = last.is_mag ? 1'b0 : last.ovf;

   // Every result traces back to an accepted request
   `CAU_ASSERT_IMPL(a_rsp_from_req, clock, reset, rsp_valid, $past(accept, 6))
   // A magnitude is never negative and never saturates
   `CAU_ASSERT_IMPL(a_mag_range, clock, reset, rsp_valid && last.is_mag, !rsp_overflow && !rsp_res_re[RES_W-1] && rsp_res_im == '0)
   // Overflow only with a part pinned at a limit
   `CAU_ASSERT_IMPL(a_ovf_pinned, clock, reset, rsp_valid && rsp_overflow, rsp_res_re == RES_MAX || rsp_res_re == RES_MIN || rsp_res_im == RES_MAX || rsp_res_im == RES_MIN)
   // An accepted request reaches the product register
   `CAU_ASSERT_NEXT(a_req_enters, clock, reset, accept, mul_q.valid)

endmodule

### sim/cau_checker.sv
// Checker for the complex arithmetic unit: predicts each request's result and compares.
module cau_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [2:0]                        req_op,
   input  logic signed [cau_pkg::DATA_W-1:0] req_a_re,
   input  logic signed [cau_pkg::DATA_W-1:0] req_a_im,
   input  logic signed [cau_pkg::DATA_W-1:0] req_b_re,
   input  logic signed [cau_pkg::DATA_W-1:0] req_b_im,
   input  logic                              rsp_valid,
   input  logic signed [cau_pkg::RES_W-1:0]  rsp_res_re,
   input  logic signed [cau_pkg::RES_W-1:0]  rsp_res_im,
   input  logic                              rsp_overflow,
   output int                                fail_count,
   output int                                pending
);
   import cau_pkg::*;

   localparam int FRAC = FRAC_BITS_DEFAULT;

   typedef struct packed {
      logic [2:0]              op;
      logic signed [RES_W-1:0] res_re;
      logic signed [RES_W-1:0] res_im;
      logic                    overflow;
   } cau_result_type;

   cau_result_type predicted_results[$];
   int mismatches = 0;
   int queued     = 0;

   assign fail_count = mismatches;
   assign pending    = queued;

   // Clamp one part to 17 bits signed; top bit flags saturation
   function automatic logic [RES_W:0] clamp_part(input longint v);
      if (v > longint'(RES_MAX)) begin
         return {1'b1, RES_MAX};
      end
      if (v < longint'(RES_MIN)) begin
         return {1'b1, RES_MIN};
      end
      return {1'b0, v[RES_W-1:0]};
   endfunction

   // Result of one request, computed at full precision
   function automatic cau_result_type predict_complex(
      input logic [2:0]                op,
      input logic signed [DATA_W-1:0]  ar,
      input logic signed [DATA_W-1:0]  ai,
      input logic signed [DATA_W-1:0]  br,
      input logic signed [DATA_W-1:0]  bi
   );
      longint         xr, xi, yr, yi, re, im, mag_sq, root, cand;
      logic           ovf_re, ovf_im;
      cau_result_type r;
      xr = longint'(ar);
      xi = longint'(ai);
      yr = longint'(br);
      yi = longint'(bi);
      re = 0;
      im = 0;
      root = 0;
      unique case (op)
         OP_ADD: begin
            re = xr + yr;
            im = xi + yi;
         end
         OP_SUB: begin
            re = xr - yr;
            im = xi - yi;
         end
         OP_MUL_RE: begin
            re = (xr * yr) >>> FRAC;
            im = (xi * yr) >>> FRAC;
         end
         OP_MUL_IM: begin
            re = (-(xi * yr)) >>> FRAC;
            im = (xr * yr) >>> FRAC;
         end
         OP_CMUL: begin
            re = (xr * yr - xi * yi) >>> FRAC;
            im = (xr * yi + xi * yr) >>> FRAC;
         end
         OP_MAG: begin
            // floor square root, one bit at a time from the top
            mag_sq = xr * xr + xi * xi;
            for (int b = ROOT_W - 1; b >= 0; b--) begin
               cand = root | (64'sd1 << b);
               if (cand * cand <= mag_sq) begin
                  root = cand;
               end
            end
            re = root;
            im = 0;
         end
         default: begin
            re = 0;
            im = 0;
         end
      endcase
      r.op = op;
      {ovf_re, r.res_re} = clamp_part(re);
      {ovf_im, r.res_im} = clamp_part(im);
      r.overflow = ovf_re | ovf_im;
      return r;
   endfunction

   // Queue a prediction per accepted request, check each strobed result
   always @(posedge clock) begin
      cau_result_type want;
      int             errs;
      errs = 0;
      if (reset) begin
         predicted_results.delete();
      end else begin
         if (start && !busy) begin
            predicted_results.push_back(predict_complex(req_op, req_a_re, req_a_im,
                                                        req_b_re, req_b_im));
         end
         if (rsp_valid) begin
            if (predicted_results.size() == 0) begin
               $display("%0t: unexpected result re %0d im %0d ovf %0b", $time,
                        rsp_res_re, rsp_res_im, rsp_overflow);
               errs++;
            end else begin
               want = predicted_results.pop_front();
               if (rsp_res_re !== want.res_re) begin
                  $display("%0t: res_re mismatch (op %0d), expected %0d, actual %0d",
                           $time, want.op, want.res_re, rsp_res_re);
                  errs++;
               end
               if (rsp_res_im !== want.res_im) begin
                  $display("%0t: res_im mismatch (op %0d), expected %0d, actual %0d",
                           $time, want.op, want.res_im, rsp_res_im);
                  errs++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $display("%0t: overflow mismatch (op %0d), expected %0b, actual %0b",
                           $time, want.op, want.overflow, rsp_overflow);
                  errs++;
               end
            end
         end
      end
      mismatches <= mismatches + errs;
      queued     <= predicted_results.size();
   end

endmodule

### sim/tb_top.sv
// Testbench top for the complex arithmetic unit: clock, reset, stimulus and verdict.
module tb_top;
   import cau_pkg::*;

   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   localparam logic signed [DATA_W-1:0] D_MAX = 16'sh7FFF;
   localparam logic signed [DATA_W-1:0] D_MIN = 16'sh8000;
   localparam logic signed [DATA_W-1:0] D_ONE = 16'sh0100;  // 1.0 in Q8.8

   localparam int RANDOM_PER_PHASE = 430;
   localparam int DRAIN_CYCLES     = 10;

   logic                     clock    = 1'b0;
   logic                     reset    = 1'b1;
   logic                     start    = 1'b0;
   logic [2:0]               req_op   = '0;
   logic signed [DATA_W-1:0] req_a_re = '0;
   logic signed [DATA_W-1:0] req_a_im = '0;
   logic signed [DATA_W-1:0] req_b_re = '0;
   logic signed [DATA_W-1:0] req_b_im = '0;
   logic                     busy;
   logic                     rsp_valid;
   logic signed [RES_W-1:0]  rsp_res_re;
   logic signed [RES_W-1:0]  rsp_res_im;
   logic                     rsp_overflow;
   int                       fail_count;
   int                       pending;

   always #1 clock = ~clock;

   complex_arithmetic_unit u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_a_re     (req_a_re),
      .req_a_im     (req_a_im),
      .req_b_re     (req_b_re),
      .req_b_im     (req_b_im),
      .rsp_valid    (rsp_valid),
      .rsp_res_re   (rsp_res_re),
      .rsp_res_im   (rsp_res_im),
      .rsp_overflow (rsp_overflow)
   );

   cau_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_a_re     (req_a_re),
      .req_a_im     (req_a_im),
      .req_b_re     (req_b_re),
      .req_b_im     (req_b_im),
      .rsp_valid    (rsp_valid),
      .rsp_res_re   (rsp_res_re),
      .rsp_res_im   (rsp_res_im),
      .rsp_overflow (rsp_overflow),
      .fail_count   (fail_count),
      .pending      (pending)
   );

   // Random gaps first, then hold start until the unit takes the request
   task automatic send_request(
      input logic [2:0]               op,
      input logic signed [DATA_W-1:0] ar,
      input logic signed [DATA_W-1:0] ai,
      input logic signed [DATA_W-1:0] br,
      input logic signed [DATA_W-1:0] bi,
      input int                       idle_pct
   );
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_op   <= op;
      req_a_re <= ar;
      req_a_im <= ai;
      req_b_re <= br;
      req_b_im <= bi;
      do @(posedge clock); while (busy);
   endtask

   // Operand mix: full range, small values near zero, and the corners
   function automatic logic signed [DATA_W-1:0] rand_operand();
      logic signed [DATA_W-1:0] v;
      case ($urandom_range(0, 9))
         0, 1: begin
            case ($urandom_range(0, 4))
               0:       v = D_MAX;
               1:       v = D_MIN;
               2:       v = '0;
               3:       v = -16'sd1;
               default: v = D_ONE;
            endcase
         end
         2, 3, 4: begin
            v = 16'($urandom_range(0, 2047));
            v = v - 16'sd1024;
         end
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   function automatic logic [2:0] rand_op();
      if ($urandom_range(0, 15) == 0) begin
         return ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
      end
      return 3'($urandom_range(0, 5));
   endfunction

   // Stimulus: directed corners, then three random phases of sender pacing
   initial begin
      int idle_pct;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sums and differences at the range limits
      send_request(OP_ADD, D_MAX, D_MAX, D_MAX, D_MAX, 23);
      send_request(OP_ADD, D_MIN, D_MIN, D_MIN, D_MIN, 23);
      send_request(OP_SUB, D_MAX, D_MIN, D_MIN, D_MAX, 23);
      send_request(OP_SUB, D_MIN, D_MAX, D_MAX, D_MIN, 23);
      // scalar products: saturation, floor of small negatives, identity
      send_request(OP_MUL_RE, D_MIN, D_MAX, D_MIN, '0, 23);
      send_request(OP_MUL_RE, -16'sd1, 16'sd1, 16'sd1, D_MAX, 23);
      send_request(OP_MUL_RE, 16'sh1234, -16'sh0567, D_ONE, 16'sh5A5A, 23);
      send_request(OP_MUL_IM, D_MIN, D_MIN, D_MIN, '0, 23);
      send_request(OP_MUL_IM, -16'sd1, 16'sd1, 16'sd1, D_MIN, 23);
      send_request(OP_MUL_IM, D_MAX, D_MAX, D_MAX, D_MAX, 23);
      // complex products
      send_request(OP_CMUL, D_MIN, D_MIN, D_MIN, D_MIN, 23);
      send_request(OP_CMUL, D_MAX, D_MAX, D_MAX, D_MIN, 23);
      send_request(OP_CMUL, D_ONE, '0, 16'sh0A5F, -16'sh3C21, 23);
      send_request(OP_CMUL, -16'sd1, '0, 16'sd1, '0, 23);
      // magnitude, with B set to random or arbitrary values since it is not used
      send_request(OP_MAG, D_MIN, D_MIN, rand_operand(), rand_operand(), 23);
      send_request(OP_MAG, D_MAX, D_MIN, '0, '0, 23);
      send_request(OP_MAG, '0, '0, D_MAX, D_MIN, 23);
      send_request(OP_MAG, 16'sh0300, 16'sh0400, '0, '0, 23);
      send_request(OP_MAG, -16'sd1, '0, '0, '0, 23);
      // unused opcodes give zero
      send_request(OP_SPARE_LO, D_MAX, D_MIN, D_MAX, D_MIN, 23);
      send_request(OP_SPARE_HI, rand_operand(), rand_operand(), rand_operand(),
                   rand_operand(), 23);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       idle_pct = 23;
            1:       idle_pct = 87;
            default: idle_pct = 0;
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_request(rand_op(), rand_operand(), rand_operand(), rand_operand(),
                         rand_operand(), idle_pct);
         end
      end
      start <= 1'b0;

      // drain the pipeline, then give late strays a chance to show up
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #400000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/cau_pkg.sv
rtl/core/cau_mult_stage.sv
rtl/core/cau_combine_stage.sv
rtl/core/cau_sqrt_stage.sv
rtl/core/complex_arithmetic_unit.sv
sim/cau_checker.sv
sim/tb_top.sv
